>>> sv/elsmc_pkg.sv
// ----------------------------------------------------------------------------
// elsmc_pkg
// Shared types and constants for the edge list store with match count.
// ----------------------------------------------------------------------------
package elsmc_pkg;

    localparam int VIN_W   = 8;
    localparam int COUNT_W = 7;
    localparam int SLOT_W  = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'h7F;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_COUNT = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic take_req;
        logic write_edge;
        logic reject;
        logic scan_clear;
        logic scan_read;
        logic load_out;
    } elsmc_cmd_t;

    typedef struct packed {
        logic req_is_count;
        logic store_full;
        logic store_empty;
        logic scan_last;
        logic out_free;
    } elsmc_sts_t;

endpackage

>>> sv/elsmc_ram.sv
// ----------------------------------------------------------------------------
// elsmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module elsmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/elsmc_ctrl.sv
// ----------------------------------------------------------------------------
// elsmc_ctrl
// Request sequencer: decode, slot scan and result hand-off.
// ----------------------------------------------------------------------------
module elsmc_ctrl
    import elsmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  elsmc_sts_t sts,
    output elsmc_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (sts.req_is_count) begin
                    cmd.scan_clear = 1'b1;
                    state_next     = sts.store_empty ? ST_RESULT : ST_SCAN;
                end else if (sts.store_full) begin
                    cmd.reject = 1'b1;
                    state_next = ST_RESULT;
                end else begin
                    cmd.write_edge = 1'b1;
                    state_next     = ST_RESULT;
                end
            end
            ST_SCAN: begin
                cmd.scan_read = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/elsmc_dp.sv
// ----------------------------------------------------------------------------
// elsmc_dp
// Datapath: request latch, fill index, edge RAM, match counter, result register.
// ----------------------------------------------------------------------------
module elsmc_dp
    import elsmc_pkg::*;
#(
    parameter int EDGE_SLOTS  = 64,
    parameter int VERTEX_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_cmd,
    input  logic [VIN_W-1:0]   in_from,
    input  logic [VIN_W-1:0]   in_to,
    input  elsmc_cmd_t         cmd,
    output elsmc_sts_t         sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               out_status,
    output logic [COUNT_W-1:0] out_count,
    output logic [SLOT_W-1:0]  out_slot
);

    localparam int ADDR_W = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
    localparam int FILL_W = $clog2(EDGE_SLOTS + 1);
    localparam int EDGE_W = 2 * VERTEX_BITS;

    logic                   req_cmd_reg;
    logic [VERTEX_BITS-1:0] req_src_reg;
    logic [VERTEX_BITS-1:0] req_dst_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [ADDR_W-1:0]      scan_addr_reg;
    logic                   rd_vld_reg;
    logic [COUNT_W-1:0]     acc_reg;
    logic                   res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic                   m_tvalid_reg;
    logic                   m_status_reg;
    logic [COUNT_W-1:0]     m_count_reg;
    logic [SLOT_W-1:0]      m_slot_reg;

    logic [VERTEX_BITS+VIN_W-1:0] from_ext;
    logic [VERTEX_BITS+VIN_W-1:0] to_ext;
    logic [FILL_W+SLOT_W-1:0]     fill_ext;
    logic [EDGE_W-1:0]            rdata;
    logic                         hit;

    assign from_ext = {{VERTEX_BITS{1'b0}}, in_from};
    assign to_ext   = {{VERTEX_BITS{1'b0}}, in_to};
    assign fill_ext = {{SLOT_W{1'b0}}, fill_reg};
    assign hit      = rd_vld_reg && (rdata == {req_src_reg, req_dst_reg});

    elsmc_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (EDGE_SLOTS)
    ) u_edge_ram (
        .aclk  (aclk),
        .we    (cmd.write_edge),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata ({req_src_reg, req_dst_reg}),
        .raddr (scan_addr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.take_req) begin
            req_cmd_reg <= in_cmd;
            req_src_reg <= from_ext[VERTEX_BITS-1:0];
            req_dst_reg <= to_ext[VERTEX_BITS-1:0];
        end
        if (cmd.scan_clear) begin
            scan_addr_reg <= '0;
        end else if (cmd.scan_read) begin
            scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
        end
        if (cmd.write_edge) begin
            res_status_reg <= STATUS_DONE;
            res_slot_reg   <= fill_ext[SLOT_W-1:0];
        end else if (cmd.reject) begin
            res_status_reg <= STATUS_FULL;
            res_slot_reg   <= '0;
        end else if (cmd.scan_clear) begin
            res_status_reg <= STATUS_DONE;
            res_slot_reg   <= '0;
        end
        if (cmd.write_edge || cmd.reject || cmd.scan_clear) begin
            acc_reg <= '0;
        end else if (hit && acc_reg != COUNT_MAX) begin
            acc_reg <= acc_reg + COUNT_W'(1);
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_count_reg  <= acc_reg;
            m_slot_reg   <= res_slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.write_edge) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            rd_vld_reg <= cmd.scan_read;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.req_is_count = (req_cmd_reg == CMD_COUNT);
        sts.store_full   = (fill_reg == FILL_W'(EDGE_SLOTS));
        sts.store_empty  = (fill_reg == '0);
        sts.scan_last    = ((FILL_W'(scan_addr_reg) + FILL_W'(1)) == fill_reg);
        sts.out_free     = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_status = m_status_reg;
    assign out_count  = m_count_reg;
    assign out_slot   = m_slot_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(EDGE_SLOTS))
        else $error("fill index beyond capacity");

    a_add_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_edge |-> !sts.store_full)
        else $error("edge written into a full store");

    a_reject_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg == STATUS_FULL)
            |-> (m_count_reg == '0 && m_slot_reg == '0))
        else $error("rejected add carries nonzero fields");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_read |-> (FILL_W'(scan_addr_reg) < fill_reg))
        else $error("scan reads an unfilled slot");
`endif

endmodule

>>> sv/edge_list_store_with_match_count.sv
// Add, and count on an empty store: DECODE, then RESULT loads the output register.
// Count: DECODE, SCAN over the filled slots at one slot per cycle, DRAIN, RESULT.
// One request at a time; the next is taken the cycle after the result is loaded
// into the output register, so a waiting result does not stall the input side.
// Reset clears the fill index and control state; RAM contents are not cleared,
// only slots below the fill index are ever read.
// ----------------------------------------------------------------------------
// edge_list_store_with_match_count
// Directed edge store with add and match-count requests over a stream port.
// ----------------------------------------------------------------------------
module edge_list_store_with_match_count
    import elsmc_pkg::*;
#(
    parameter int EDGE_SLOTS  = 64,
    parameter int VERTEX_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // from_vertex[7:0], to_vertex[15:8]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // match_count[6:0], slot_used[12:7], zero[15:13]
    output logic [0:0]  m_tuser    // status[0]
);

    elsmc_cmd_t         cmd;
    elsmc_sts_t         sts;
    logic               out_status;
    logic [COUNT_W-1:0] out_count;
    logic [SLOT_W-1:0]  out_slot;

    elsmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    elsmc_dp #(
        .EDGE_SLOTS  (EDGE_SLOTS),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_tuser[0]),
        .in_from    (s_tdata[7:0]),
        .in_to      (s_tdata[15:8]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_count  (out_count),
        .out_slot   (out_slot)
    );

    assign m_tdata = {3'b000, out_slot, out_count};
    assign m_tuser = out_status;

endmodule

>>> verif/edge_list_store_with_match_count_tb.sv
// ----------------------------------------------------------------------------
// edge_list_store_with_match_count_tb
// Drives add and count requests into the edge store over the stream ports with
// random gaps on both sides. Each accepted request is predicted by a local
// copy of the edge table, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module edge_list_store_with_match_count_tb;
    import elsmc_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_REQS  = 630;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic               status;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  slot;
    } edge_answer_t;

    class edge_count_scoreboard;
        logic [VIN_W-1:0] src_mem [TABLE_DEPTH];
        logic [VIN_W-1:0] dst_mem [TABLE_DEPTH];
        bit               used    [TABLE_DEPTH];
        int unsigned      fill_level;
        edge_answer_t     pending_answers [$];
        int               fail_count;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                src_mem[i] = '0;
                dst_mem[i] = '0;
                used[i]    = 1'b0;
            end
            fill_level = 0;
            fail_count = 0;
        endfunction

        function void note_request(logic cmd, logic [VIN_W-1:0] src,
                                   logic [VIN_W-1:0] dst);
            edge_answer_t ans;
            bit placed;
            ans.status = STATUS_DONE;
            ans.count  = '0;
            ans.slot   = '0;
            placed     = 1'b0;
            if (cmd == CMD_COUNT) begin
                for (int i = 0; i < fill_level; i++)
                    if (used[i] && src_mem[i] == src && dst_mem[i] == dst
                        && ans.count != COUNT_MAX)
                        ans.count++;
            end else if (fill_level < TABLE_DEPTH) begin
                src_mem[fill_level] = src;
                dst_mem[fill_level] = dst;
                used[fill_level]    = 1'b1;
                ans.slot            = fill_level[SLOT_W-1:0];
                fill_level++;
            end else begin
                for (int i = 0; i < TABLE_DEPTH && !placed; i++) begin
                    if (!used[i]) begin
                        src_mem[i] = src;
                        dst_mem[i] = dst;
                        used[i]    = 1'b1;
                        ans.slot   = i[SLOT_W-1:0];
                        placed     = 1'b1;
                    end
                end
                if (!placed)
                    ans.status = STATUS_FULL;
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_result(logic status, logic [COUNT_W-1:0] count,
                                   logic [SLOT_W-1:0] slot);
            edge_answer_t exp_ans;
            if (pending_answers.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status=%0d count=%0d slot=%0d",
                             status, count, slot);
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (status !== exp_ans.status || count !== exp_ans.count
                || slot !== exp_ans.slot) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"mismatch: expected status=%0d count=%0d slot=%0d,",
                              " got status=%0d count=%0d slot=%0d"},
                             exp_ans.status, exp_ans.count, exp_ans.slot,
                             status, count, slot);
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    edge_count_scoreboard sb;
    bit                   no_gaps = 1'b0;
    int                   cycle_count = 0;

    edge_list_store_with_match_count uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata[6:0], m_tdata[12:7]);
    end

    // result side backpressure
    initial begin : ready_driver
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_request(logic cmd, logic [VIN_W-1:0] src, logic [VIN_W-1:0] dst);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, src};
        s_tuser  <= cmd;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_request(cmd, src, dst);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [VIN_W-1:0] pool_src [6];
        logic [VIN_W-1:0] pool_dst [6];
        logic             cmd;
        logic [VIN_W-1:0] src;
        logic [VIN_W-1:0] dst;
        int               k;

        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ADD;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty store, extremes, duplicates, partial matches
        send_request(CMD_COUNT, 8'h00, 8'h00);
        send_request(CMD_ADD,   8'h00, 8'h00);
        send_request(CMD_ADD,   8'hFF, 8'hFF);
        send_request(CMD_ADD,   8'h00, 8'hFF);
        send_request(CMD_ADD,   8'hFF, 8'h00);
        send_request(CMD_ADD,   8'h00, 8'h00);
        send_request(CMD_COUNT, 8'h00, 8'h00);
        send_request(CMD_COUNT, 8'hFF, 8'hFF);
        send_request(CMD_COUNT, 8'h00, 8'hFF);
        send_request(CMD_COUNT, 8'hFF, 8'h00);
        send_request(CMD_COUNT, 8'h01, 8'h01);
        send_request(CMD_ADD,   8'hAA, 8'h55);
        send_request(CMD_ADD,   8'h55, 8'hAA);
        send_request(CMD_COUNT, 8'hAA, 8'h55);
        send_request(CMD_COUNT, 8'h55, 8'hAA);
        send_request(CMD_COUNT, 8'hAA, 8'hAA);
        send_request(CMD_COUNT, 8'h55, 8'h55);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();

        pool_src = '{8'h00, 8'hFF, 8'h3C, 8'hAA, 8'h01, 8'h80};
        pool_dst = '{8'h00, 8'hFF, 8'hC3, 8'h55, 8'h80, 8'h01};

        // random: small vertex pool so counts hit, enough adds to fill the store
        for (int n = 0; n < RANDOM_REQS; n++) begin
            no_gaps = (n >= 200 && n < 300);
            if (n == 400) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait_drained();
            end
            cmd = ($urandom_range(0, 99) < 50) ? CMD_ADD : CMD_COUNT;
            if ($urandom_range(0, 99) < 65) begin
                k   = $urandom_range(0, 5);
                src = pool_src[k];
                dst = ($urandom_range(0, 3) == 0) ? pool_dst[$urandom_range(0, 5)]
                                                  : pool_dst[k];
            end else begin
                src = VIN_W'($urandom_range(0, 255));
                dst = VIN_W'($urandom_range(0, 255));
            end
            send_request(cmd, src, dst);
        end
        no_gaps = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
